[hw/rtl/terl_pkg.sv]
// Shared types and constants for the timestamped event ring log.
// Holds the log depth, field widths and the operation codes.
// Depends on nothing; every other file of the block but terl_ram imports it.
package terl_pkg;

    // Number of entries in the ring.
    localparam int LOG_DEPTH = 16;

    // Derived widths: slot index, and a count that can hold LOG_DEPTH itself.
    localparam int PTR_W = $clog2(LOG_DEPTH);
    localparam int CNT_W = $clog2(LOG_DEPTH + 1);
    // Wide enough for a start slot plus any in-range logical index.
    localparam int SUM_W = PTR_W + 1;

    // Field widths fixed by the interface.
    localparam int FUNC_W      = 2;
    localparam int KIND_W      = 8;
    localparam int DATA_W      = 32;
    localparam int STAMP_W     = 32;
    localparam int IDX_W       = 8;
    localparam int COUNT_OUT_W = 5;

    // Width used to compare a logical index against the count.
    localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

    // One stored entry: timestamp, kind and payload side by side.
    localparam int ENTRY_W = STAMP_W + KIND_W + DATA_W;

    // Stream widths; the result tdata is padded to whole bytes.
    localparam int S_TDATA_W = KIND_W + DATA_W + IDX_W + STAMP_W;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_FIELD_W = STAMP_W + KIND_W + DATA_W + COUNT_OUT_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;
    localparam int M_TUSER_W = 1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_TIME  = 2'd3
    } func_t;

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_RESULT = 2'b10
    } ctrl_state_t;

endpackage

[hw/rtl/terl_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the entry store of the event log; depends on nothing.
module terl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/terl_ctrl.sv]
// Handshake controller for the event log: takes an item, then holds the result.
// Depends on terl_pkg for the state encoding.
module terl_ctrl
    import terl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output logic accept
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    logic idle;
    logic holding;

    assign idle     = (state_reg == ST_IDLE);
    assign holding  = (state_reg == ST_RESULT);

    // A new item may enter in the same cycle that the held result leaves.
    assign s_tready = idle || (holding && m_tready);
    assign m_tvalid = holding;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        priority if (accept)
        begin
            state_next = ST_RESULT;
        end
        else if (holding && m_tready)
        begin
            state_next = ST_IDLE;
        end
        else
        begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/terl_dp.sv]
// Datapath of the event log: pointer, count, uptime, entry RAM and result fields.
// Depends on terl_pkg and instantiates terl_ram.
module terl_dp
    import terl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [FUNC_W-1:0]      func,
    input  logic [KIND_W-1:0]      event_kind,
    input  logic [DATA_W-1:0]      event_payload,
    input  logic [IDX_W-1:0]       read_index,
    input  logic [STAMP_W-1:0]     time_ms,
    output logic                   read_ok,
    output logic [STAMP_W-1:0]     entry_timestamp,
    output logic [KIND_W-1:0]      entry_kind,
    output logic [DATA_W-1:0]      entry_payload,
    output logic [COUNT_OUT_W-1:0] entry_count
);

    logic [PTR_W-1:0]   ptr_reg;
    logic [PTR_W-1:0]   ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [STAMP_W-1:0] uptime_reg;
    logic [STAMP_W-1:0] uptime_next;
    logic               ok_reg;
    logic               ok_next;

    func_t              op;
    logic               full;
    logic               hit;
    logic [PTR_W-1:0]   start;
    logic [SUM_W-1:0]   sum;
    logic [PTR_W-1:0]   slot;
    logic               do_write;
    logic               do_read;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] rd_entry;

    assign op   = func_t'(func);
    assign full = (count_reg == CNT_W'(LOG_DEPTH));
    assign hit  = (CMP_W'(read_index) < CMP_W'(count_reg));

    // Oldest entry sits at slot zero until the ring wraps, then at the pointer.
    assign start = full ? ptr_reg : '0;
    assign sum   = SUM_W'(start) + SUM_W'(read_index);
    assign slot  = (sum >= SUM_W'(LOG_DEPTH)) ? PTR_W'(sum - SUM_W'(LOG_DEPTH))
                                              : PTR_W'(sum);

    assign do_write = accept && (op == FUNC_ADD);
    assign do_read  = accept && (op == FUNC_READ) && hit;
    assign wr_entry = {uptime_reg, event_kind, event_payload};

    always_comb
    begin
        ptr_next    = ptr_reg;
        count_next  = count_reg;
        uptime_next = uptime_reg;
        ok_next     = ok_reg;
        if (accept)
        begin
            ok_next = 1'b0;
            unique case (op)
                FUNC_ADD:
                begin
                    ptr_next = (ptr_reg == PTR_W'(LOG_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                    if (!full)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                FUNC_READ:
                begin
                    ok_next = hit;
                end
                FUNC_CLEAR:
                begin
                    ptr_next   = '0;
                    count_next = '0;
                end
                FUNC_TIME:
                begin
                    uptime_next = time_ms;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            count_reg  <= '0;
            uptime_reg <= '0;
            ok_reg     <= 1'b0;
        end
        else
        begin
            ptr_reg    <= ptr_next;
            count_reg  <= count_next;
            uptime_reg <= uptime_next;
            ok_reg     <= ok_next;
        end
    end

    terl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LOG_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (do_write),
        .waddr (ptr_reg),
        .wdata (wr_entry),
        .re    (do_read),
        .raddr (slot),
        .rdata (rd_entry)
    );

    // The RAM output only changes on a read hit, so it holds while the result waits.
    assign read_ok         = ok_reg;
    assign entry_timestamp = ok_reg ? rd_entry[ENTRY_W-1 -: STAMP_W] : '0;
    assign entry_kind      = ok_reg ? rd_entry[DATA_W +: KIND_W] : '0;
    assign entry_payload   = ok_reg ? rd_entry[DATA_W-1:0] : '0;
    assign entry_count     = COUNT_OUT_W'(count_reg);

endmodule

[hw/rtl/timestamped_event_ring_log.sv]
// Top level of the timestamped event ring log.
// Joins the handshake controller (terl_ctrl) and the datapath (terl_dp).
// Depends on terl_pkg, terl_ctrl, terl_dp and terl_ram.
//
//  Port group   Way   Payload
//  s_*          in    tuser: func; tdata: event_kind, event_payload, read_index, time_ms
//  m_*          out   tuser: read_ok; tdata: timestamp, kind, payload, entry count
//
// Every accepted transaction yields exactly one result transaction, shown in the next cycle.
// With the output drained every cycle the log takes one item per cycle; the figure is
// set by the single registered read port of the entry RAM, which holds the result data.
// A new item is taken only while no result is held, or in the cycle the held result leaves.
// Reset (rst_n low, asynchronous) empties the log and zeroes the uptime; the entry RAM
// is not cleared, since only entries written since the last clear can ever be read.
// A stall on the output side holds the result and stops input acceptance.
module timestamped_event_ring_log
    import terl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // From bit 0: event_kind[7:0], event_payload[39:8], read_index[47:40], time_ms[79:48].
    input  logic [S_TDATA_W-1:0] s_tdata,
    // From bit 0: func[1:0].
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // From bit 0: entry_timestamp[31:0], entry_kind[39:32], entry_payload[71:40],
    // entry_count[76:72], zero padding above.
    output logic [M_TDATA_W-1:0] m_tdata,
    // From bit 0: read_ok[0].
    output logic [M_TUSER_W-1:0] m_tuser
);

    logic                   accept;
    logic                   read_ok;
    logic [STAMP_W-1:0]     entry_timestamp;
    logic [KIND_W-1:0]      entry_kind;
    logic [DATA_W-1:0]      entry_payload;
    logic [COUNT_OUT_W-1:0] entry_count;

    // Unpack the input transaction.
    logic [KIND_W-1:0]  event_kind;
    logic [DATA_W-1:0]  event_payload;
    logic [IDX_W-1:0]   read_index;
    logic [STAMP_W-1:0] time_ms;

    assign event_kind    = s_tdata[KIND_W-1:0];
    assign event_payload = s_tdata[KIND_W +: DATA_W];
    assign read_index    = s_tdata[KIND_W + DATA_W +: IDX_W];
    assign time_ms       = s_tdata[KIND_W + DATA_W + IDX_W +: STAMP_W];

    // The controller owns the handshake and tells the datapath when an item is taken.
    terl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .accept   (accept)
    );

    // The datapath updates pointer, count and uptime and produces the result fields.
    terl_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .func            (s_tuser),
        .event_kind      (event_kind),
        .event_payload   (event_payload),
        .read_index      (read_index),
        .time_ms         (time_ms),
        .read_ok         (read_ok),
        .entry_timestamp (entry_timestamp),
        .entry_kind      (entry_kind),
        .entry_payload   (entry_payload),
        .entry_count     (entry_count)
    );

    // Pack the result transaction.
    assign m_tdata = {{M_PAD_W{1'b0}}, entry_count, entry_payload, entry_kind,
                      entry_timestamp};
    assign m_tuser = read_ok;

    // Every accepted item shows its result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("no result after an accepted item");

    // Only a read can report a found entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser != FUNC_READ)) |=> !m_tuser[0])
        else $error("read_ok set by an item that is not a read");

    // A clear leaves an empty log.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == FUNC_CLEAR)) |=> (entry_count == '0))
        else $error("count not zero after clear");

    // Fields of an unsuccessful result are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |->
            ((entry_timestamp == '0) && (entry_kind == '0) && (entry_payload == '0)))
        else $error("nonzero entry fields without a found entry");

endmodule
